// ===== sv/bpa_pkg.sv =====
`default_nettype none
package bpa_pkg;

  // Pool geometry.
  localparam int POOL_PAGES = 1024;
  localparam int WORD_W     = (POOL_PAGES < 32) ? POOL_PAGES : 32;
  localparam int WORDS      = POOL_PAGES / WORD_W;
  localparam int WB         = $clog2(WORD_W);
  localparam int WORD_AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int ROWS       = 2 ** (WORD_AW + 1);
  localparam int ADDR_W     = WORD_AW + 1;

  // Field widths.
  localparam int PAGE_W = 52;
  localparam int CNT_W  = 11;
  localparam int IDX_W  = $clog2(POOL_PAGES) + 1;
  localparam int CW     = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int XW     = CW + 1;

  // Actions.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NOFIT  = 2'd1;
  localparam logic [1:0] STAT_NOPOOL = 2'd2;
  localparam logic [1:0] STAT_RANGE  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_KBASE  = 2'd0;
  localparam logic [1:0] CFG_KCOUNT = 2'd1;
  localparam logic [1:0] CFG_UBASE  = 2'd2;
  localparam logic [1:0] CFG_UCOUNT = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_DEC2,
    S_SCAN_RD,
    S_SCAN_EV,
    S_MOD_RD,
    S_MOD_WR,
    S_DONE
  } bpa_state_t;

  // Bitmap memory request.
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } bpa_mem_req_t;

endpackage
`default_nettype wire

// ===== sv/bpa_bitmap.sv =====
`default_nettype none
module bpa_bitmap (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bpa_pkg::bpa_mem_req_t         req,
  output logic [bpa_pkg::WORD_W-1:0]         rdata
);
  import bpa_pkg::*;

  logic [WORD_W-1:0] mem [ROWS];
  logic [ROWS-1:0]   row_valid;

  // A row never written reads as all free.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (req.wr) begin
      row_valid[req.addr] <= 1'b1;
    end
  end

  // Storage and registered read port.
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= row_valid[req.addr] ? mem[req.addr] : '0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bitmap_page_allocator_top.sv =====
// Allocate scans bitmap words from the first one up to the fit, then marks the words of the run;
// free checks each word of the range, then clears the same words.
// One item at a time: the single-port bitmap memory is read and written word by word.
// Results are a one-cycle done strobe; the receiver cannot stall.
// Reset: synchronous; all pages free, registers at their documented reset values.
`default_nettype none
module bitmap_page_allocator_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        action,
  input  wire logic                        use_user_pool,
  input  wire logic [bpa_pkg::CNT_W-1:0]   page_count,
  input  wire logic [bpa_pkg::PAGE_W-1:0]  page_number,
  output logic                             done,
  output logic [1:0]                       status,
  output logic [bpa_pkg::PAGE_W-1:0]       result_page,
  output logic                             from_user_pool,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [bpa_pkg::PAGE_W-1:0]  cfg_data
);
  import bpa_pkg::*;

  bpa_state_t state, state_next;

  logic [PAGE_W-1:0]  kbase, ubase;
  logic [CNT_W-1:0]   kcount, ucount;

  logic               op, pool;
  logic [XW-1:0]      cnt;
  logic [PAGE_W-1:0]  page, base;
  logic [XW-1:0]      n, lo, hi, carry;
  logic [WORD_AW-1:0] word, last;
  logic               in_k, in_u;
  logic [XW-1:0]      diff_k, diff_u;

  logic [XW-1:0]      kn, un;
  bpa_mem_req_t       req;
  logic [WORD_W-1:0]  rdata;

  logic [WORD_W-1:0]  mask, hit_vec;
  logic               scan_hit;
  logic [WB-1:0]      hit_j;
  logic [XW-1:0]      carry_new;
  logic               chk_ok;
  logic               last_word;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);
  assign last_word = (word == last);

  assign kn = (XW'(kcount) > XW'(POOL_PAGES)) ? XW'(POOL_PAGES) : XW'(kcount);
  assign un = (XW'(ucount) > XW'(POOL_PAGES)) ? XW'(POOL_PAGES) : XW'(ucount);

  bpa_bitmap u_bitmap (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      kbase  <= '0;
      kcount <= CNT_W'(1024);
      ubase  <= PAGE_W'(1024);
      ucount <= CNT_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KBASE:  kbase  <= cfg_data;
        CFG_KCOUNT: kcount <= cfg_data[CNT_W-1:0];
        CFG_UBASE:  ubase  <= cfg_data;
        CFG_UCOUNT: ucount <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Word evaluation: run lengths for the first-fit scan and the range mask.
  always_comb begin
    logic [WORD_W-1:0] used_w;
    logic [XW-1:0]     pos;
    logic              found;
    logic [WB-1:0]     lastk;
    logic [XW-1:0]     run;
    used_w    = '0;
    mask      = '0;
    hit_vec   = '0;
    carry_new = '0;
    for (int j = 0; j < WORD_W; j++) begin
      pos       = (XW'(word) << WB) | XW'(j);
      used_w[j] = rdata[j] | (pos >= n);
      mask[j]   = (pos >= lo) && (pos < hi);
    end
    for (int j = 0; j < WORD_W; j++) begin
      found = 1'b0;
      lastk = '0;
      for (int k = 0; k < WORD_W; k++) begin
        if (k <= j && used_w[k]) begin
          found = 1'b1;
          lastk = WB'(k);
        end
      end
      run        = found ? (XW'(j) - XW'(lastk)) : (carry + XW'(j) + XW'(1));
      hit_vec[j] = (run >= cnt);
      if (j == WORD_W - 1) begin
        carry_new = run;
      end
    end
    scan_hit = |hit_vec;
    hit_j    = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_j = WB'(j);
      end
    end
    chk_ok = ((rdata & mask) == mask);
  end

  // Memory requests.
  always_comb begin
    req.rd    = (state == S_SCAN_RD) || (state == S_MOD_RD);
    req.wr    = (state == S_MOD_WR);
    req.addr  = {pool, word};
    req.wdata = (op == ACT_FREE) ? (rdata & ~mask) : (rdata | mask);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DEC;
      end
      S_DEC: state_next = S_DEC2;
      S_DEC2: begin
        if (op == ACT_ALLOC) begin
          if (cnt == '0 || cnt > (pool ? un : kn)) state_next = S_DONE;
          else                                     state_next = S_SCAN_RD;
        end else if (page == '0 || cnt == '0 || !(in_k || in_u)) begin
          state_next = S_DONE;
        end else if (((in_k ? diff_k : diff_u) + cnt) > (in_k ? kn : un)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_next = S_SCAN_EV;
      S_SCAN_EV: begin
        if (op == ACT_ALLOC) begin
          if (scan_hit)       state_next = S_MOD_RD;
          else if (last_word) state_next = S_DONE;
          else                state_next = S_SCAN_RD;
        end else begin
          if (!chk_ok)        state_next = S_DONE;
          else if (last_word) state_next = S_MOD_RD;
          else                state_next = S_SCAN_RD;
        end
      end
      S_MOD_RD: state_next = S_MOD_WR;
      S_MOD_WR: state_next = last_word ? S_DONE : S_MOD_RD;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    logic [XW-1:0] idx;
    idx = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          op   <= action;
          pool <= use_user_pool;
          cnt  <= XW'(page_count);
          page <= page_number;
        end
      end
      S_DEC: begin
        in_k   <= (page >= kbase) &&
                  ({1'b0, page} < ({1'b0, kbase} + (PAGE_W+1)'(kn)));
        in_u   <= (page >= ubase) &&
                  ({1'b0, page} < ({1'b0, ubase} + (PAGE_W+1)'(un)));
        diff_k <= XW'(page - kbase);
        diff_u <= XW'(page - ubase);
      end
      S_DEC2: begin
        status      <= STAT_OK;
        result_page <= '0;
        carry       <= '0;
        if (op == ACT_ALLOC) begin
          base           <= pool ? ubase : kbase;
          n              <= pool ? un : kn;
          from_user_pool <= pool;
          word           <= '0;
          last           <= WORD_AW'(((pool ? un : kn) - XW'(1)) >> WB);
          if (cnt == '0) result_page <= pool ? ubase : kbase;
          else if (cnt > (pool ? un : kn)) status <= STAT_NOFIT;
        end else begin
          from_user_pool <= 1'b0;
          if (page != '0 && cnt != '0) begin
            if (!(in_k || in_u)) begin
              status <= STAT_NOPOOL;
            end else begin
              idx            = in_k ? diff_k : diff_u;
              pool           <= !in_k;
              from_user_pool <= !in_k;
              n              <= in_k ? kn : un;
              lo             <= idx;
              hi             <= idx + cnt;
              word           <= WORD_AW'(idx >> WB);
              last           <= WORD_AW'((idx + cnt - XW'(1)) >> WB);
              if ((idx + cnt) > (in_k ? kn : un)) status <= STAT_RANGE;
            end
          end
        end
      end
      S_SCAN_EV: begin
        if (op == ACT_ALLOC) begin
          if (scan_hit) begin
            idx         = ((XW'(word) << WB) | XW'(hit_j)) + XW'(1) - cnt;
            result_page <= base + PAGE_W'(idx);
            lo          <= idx;
            hi          <= idx + cnt;
            word        <= WORD_AW'(idx >> WB);
            last        <= WORD_AW'((idx + cnt - XW'(1)) >> WB);
          end else if (last_word) begin
            status <= STAT_NOFIT;
          end else begin
            carry <= carry_new;
            word  <= word + WORD_AW'(1);
          end
        end else begin
          if (!chk_ok)        status <= STAT_RANGE;
          else if (last_word) word   <= WORD_AW'(lo >> WB);
          else                word   <= word + WORD_AW'(1);
        end
      end
      S_MOD_WR: begin
        if (!last_word) word <= word + WORD_AW'(1);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/bpa_checker.sv =====
`default_nettype none
module bpa_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       done,
  input wire logic [1:0]                 status,
  input wire logic [bpa_pkg::PAGE_W-1:0] result_page,
  input wire logic                       from_user_pool,
  input wire logic                       cfg_valid,
  input wire logic                       cfg_ready
);
  import bpa_pkg::*;

  // An accepted transfer makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted item did not raise busy");

  // A result is only delivered while an item is in flight.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result strobe without an item in flight");

  // The block returns to idle right after a result.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy) else $error("block not idle after result");

  // A page in no pool gives no page and no pool.
  a_nopool: assert property (@(posedge clk) disable iff (rst)
    done && status == STAT_NOPOOL |-> result_page == '0 && !from_user_pool)
    else $error("bad fields on page-in-no-pool result");

  // Configuration writes are always taken.
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready) else $error("configuration write refused");

endmodule

bind bitmap_page_allocator_top bpa_checker u_bpa_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .status         (status),
  .result_page    (result_page),
  .from_user_pool (from_user_pool),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready)
);
`default_nettype wire
